// ===== src/mdc45_pkg.sv =====
// Shared types, codes and constants of the Clause 45 management master.
package mdc45_pkg;

    // Operation codes carried by an input word.
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_START_READ  = 2'd1;
    localparam logic [1:0] OP_START_WRITE = 2'd2;

    // Classes the front end assigns to an input word.
    localparam logic [1:0] CLS_TICK     = 2'd0;
    localparam logic [1:0] CLS_START_RD = 2'd1;
    localparam logic [1:0] CLS_START_WR = 2'd2;
    localparam logic [1:0] CLS_NONE     = 2'd3;

    // Transaction kinds held by the sequencer.
    localparam logic [1:0] KIND_IDLE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_IDLE_TICK = 2'd2;

    // Frame opcodes.
    localparam logic [1:0] OPC_ADDR  = 2'b00;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_READ  = 2'b11;

    localparam int unsigned PREAMBLE_W        = 6;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = 6'd32;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [1:0]  cls;
        logic [4:0]  port;
        logic [4:0]  device;
        logic [15:0] reg_addr;
        logic [15:0] wr_data;
        logic        sample;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_rd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        clock_pulse;
        logic        data_level;
        logic        drive_enable;
        logic        done_res;
        logic [15:0] read_data;
    } result_t;

endpackage

// ===== src/mdc45_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface mdc45_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  phy_address;
    logic [4:0]  device_address;
    logic [15:0] register_address;
    logic [15:0] write_data;
    logic        mdio_sample;

    modport source (output valid, output operation, output phy_address,
                    output device_address, output register_address,
                    output write_data, output mdio_sample, input ready);
    modport sink (input valid, input operation, input phy_address,
                  input device_address, input register_address,
                  input write_data, input mdio_sample, output ready);
endinterface

interface mdc45_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        clock_pulse;
    logic        data_level;
    logic        drive_enable;
    logic        done_res;
    logic [15:0] read_data;

    modport source (output valid, output status, output clock_pulse,
                    output data_level, output drive_enable, output done_res,
                    output read_data, input ready);
    modport sink (input valid, input status, input clock_pulse,
                  input data_level, input drive_enable, input done_res,
                  input read_data, output ready);
endinterface

// ===== src/mdc45_fifo.sv =====
// Short register queue between the front end and the sequencer.
module mdc45_fifo #(
    parameter int unsigned DEPTH = mdc45_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  mdc45_pkg::item_t     push_item,
    output logic                 push_ready,
    output mdc45_pkg::queue_rd_t pop,
    input  logic                 pop_ready
);
    import mdc45_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mdc45_front.sv =====
// Front end: accepts input words, classifies them and queues them.
module mdc45_front #(
    parameter int unsigned QUEUE_DEPTH = mdc45_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mdc45_in_if.sink             req,
    output mdc45_pkg::queue_rd_t pop,
    input  logic                 pop_ready
);
    import mdc45_pkg::*;

    item_t item;

    always_comb
    begin
        item.port     = req.phy_address;
        item.device   = req.device_address;
        item.reg_addr = req.register_address;
        item.wr_data  = req.write_data;
        item.sample   = req.mdio_sample;
        case (req.operation)
            OP_TICK:        item.cls = CLS_TICK;
            OP_START_READ:  item.cls = CLS_START_RD;
            OP_START_WRITE: item.cls = CLS_START_WR;
            default:        item.cls = CLS_NONE;
        endcase
    end

    mdc45_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req.valid),
        .push_item  (item),
        .push_ready (req.ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

endmodule

// ===== src/mdc45_back.sv =====
// Sequencer: walks the frame bit by bit and registers each result word.
module mdc45_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [mdc45_pkg::PREAMBLE_W-1:0]     preamble,
    input  mdc45_pkg::queue_rd_t                 pop,
    output logic                                 pop_ready,
    mdc45_out_if.source                          rsp
);
    import mdc45_pkg::*;

    typedef struct packed {
        logic lvl;
        logic en;
        logic shift;
    } period_t;

    // One period of a 32-period frame at offset o.
    function automatic period_t frame_period(input logic [4:0] o,
                                             input logic [1:0] opcode,
                                             input logic read_frame,
                                             input logic [15:0] word,
                                             input logic [4:0] port,
                                             input logic [4:0] dev);
        period_t     r;
        logic [4:0]  port_idx;
        logic [4:0]  dev_idx;
        logic [4:0]  word_idx;
        port_idx = 5'd8 - o;
        dev_idx  = 5'd13 - o;
        word_idx = 5'd31 - o;
        r.en    = 1'b1;
        r.lvl   = 1'b0;
        r.shift = 1'b0;
        if (o < 5'd2)
        begin
            r.lvl = 1'b0;
        end
        else if (o < 5'd4)
        begin
            r.lvl = (o == 5'd2) ? opcode[1] : opcode[0];
        end
        else if (o < 5'd9)
        begin
            r.lvl = port[port_idx[2:0]];
        end
        else if (o < 5'd14)
        begin
            r.lvl = dev[dev_idx[2:0]];
        end
        else if (read_frame)
        begin
            r.en    = 1'b0;
            r.shift = (o >= 5'd16);
        end
        else if (o < 5'd16)
        begin
            r.lvl = (o == 5'd14);
        end
        else
        begin
            r.lvl = word[word_idx[3:0]];
        end
        return r;
    endfunction

    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  pos_reg, pos_next;
    logic [4:0]  port_reg, port_next;
    logic [4:0]  dev_reg, dev_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] data_reg, data_next;
    logic [15:0] shift_reg, shift_next;
    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     res;

    logic        fire;
    logic        is_read;
    logic [8:0]  p9, seg2, seg3, seg4, total, pos9;
    logic [8:0]  off_a, off_b;
    period_t     per;

    assign pop_ready = !out_valid_reg || rsp.ready;
    assign fire      = pop.valid && pop_ready;
    assign is_read   = (kind_reg == KIND_READ);

    assign p9    = {3'b000, preamble};
    assign seg2  = p9 + 9'd32;
    assign seg3  = {p9[7:0], 1'b0} + 9'd32;
    assign seg4  = {p9[7:0], 1'b0} + 9'd64;
    assign total = seg4 + (is_read ? p9 : 9'd0);
    assign pos9  = {1'b0, pos_reg};
    assign off_a = pos9 - p9;
    assign off_b = pos9 - seg3;

    always_comb
    begin
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        port_next  = port_reg;
        dev_next   = dev_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        shift_next = shift_reg;
        res        = '0;
        per        = '{lvl: 1'b1, en: 1'b1, shift: 1'b0};

        if (pos9 >= total)
        begin
            per = '{lvl: 1'b1, en: 1'b1, shift: 1'b0};
        end
        else if (pos9 < p9)
        begin
            per = '{lvl: 1'b1, en: 1'b1, shift: 1'b0};
        end
        else if (pos9 < seg2)
        begin
            per = frame_period(off_a[4:0], OPC_ADDR, 1'b0, addr_reg, port_reg, dev_reg);
        end
        else if (pos9 < seg3)
        begin
            per = '{lvl: 1'b1, en: 1'b1, shift: 1'b0};
        end
        else if (pos9 < seg4)
        begin
            per = frame_period(off_b[4:0], is_read ? OPC_READ : OPC_WRITE, is_read,
                               data_reg, port_reg, dev_reg);
        end

        if (fire)
        begin
            case (pop.item.cls)
                CLS_START_RD, CLS_START_WR:
                begin
                    if (kind_reg != KIND_IDLE)
                    begin
                        res.status = ST_BUSY;
                    end
                    else
                    begin
                        kind_next  = (pop.item.cls == CLS_START_RD) ? KIND_READ
                                                                     : KIND_WRITE;
                        port_next  = pop.item.port;
                        dev_next   = pop.item.device;
                        addr_next  = pop.item.reg_addr;
                        data_next  = pop.item.wr_data;
                        shift_next = '0;
                        pos_next   = '0;
                    end
                end
                CLS_TICK:
                begin
                    if (kind_reg == KIND_IDLE)
                    begin
                        res.status = ST_IDLE_TICK;
                    end
                    else
                    begin
                        if (per.shift)
                        begin
                            shift_next = {shift_reg[14:0], pop.item.sample};
                        end
                        res.status       = ST_OK;
                        res.clock_pulse  = 1'b1;
                        res.data_level   = per.lvl;
                        res.drive_enable = per.en;
                        if (pos9 >= total - 9'd1)
                        begin
                            res.done_res = 1'b1;
                            if (is_read)
                            begin
                                res.read_data = shift_next;
                            end
                            kind_next = KIND_IDLE;
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_IDLE;
            pos_reg       <= '0;
            port_reg      <= '0;
            dev_reg       <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg  <= kind_next;
            pos_reg   <= pos_next;
            port_reg  <= port_next;
            dev_reg   <= dev_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            shift_reg <= shift_next;
            if (pop_ready)
            begin
                out_valid_reg <= pop.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_res_reg.status;
    assign rsp.clock_pulse  = out_res_reg.clock_pulse;
    assign rsp.data_level   = out_res_reg.data_level;
    assign rsp.drive_enable = out_res_reg.drive_enable;
    assign rsp.done_res     = out_res_reg.done_res;
    assign rsp.read_data    = out_res_reg.read_data;

endmodule

// ===== src/mdio_clause45_master_core.sv =====
// An accepted word is first written into the queue; the back end then pops it, steps the
// sequencer and registers the result word in its output stage.
// Throughput: one word per cycle while result words are taken; a stalled result holds the back end.
// The queue between front end and sequencer lets either side stall without losing words.
// Reset (rst_n, asynchronous, active low) empties the queue and output stage, returns the
// sequencer to idle with all latches cleared, and sets the preamble length to 32.
module mdio_clause45_master_core #(
    parameter int unsigned QUEUE_DEPTH = mdc45_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mdc45_pkg::PREAMBLE_W-1:0] cfg_wr_data,
    mdc45_in_if.sink                         req,
    mdc45_out_if.source                      rsp
);
    import mdc45_pkg::*;

    // The preamble length is read by the sequencer on every tick, so the segment
    // boundaries of a frame follow this register directly.
    logic [PREAMBLE_W-1:0] preamble_reg;
    queue_rd_t             pop;
    logic                  pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= PREAMBLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            preamble_reg <= cfg_wr_data;
        end
    end

    // The front end decodes the operation of each word and places it in the queue.
    mdc45_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // The back end takes one queued word per cycle whenever its output stage is free
    // or being emptied, advances the transaction and registers the result word.
    mdc45_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .preamble  (preamble_reg),
        .pop       (pop),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule

// ===== src/mdc45_checker.sv =====
// Port-level checks of the management master, bound to its top level.
module mdc45_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        clock_pulse,
    input logic        data_level,
    input logic        drive_enable,
    input logic        done_res,
    input logic [15:0] read_data
);
    import mdc45_pkg::*;

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data)
        && $stable(done_res) && $stable(data_level) && $stable(drive_enable))
        else $error("result word changed while stalled");

    // Only a clock period may drive, release or end a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !clock_pulse |-> !data_level && !drive_enable && !done_res)
        else $error("pin activity without a clock period");

    // A released period reads back as low and is always a good clock period.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clock_pulse && !drive_enable |-> !data_level && status == ST_OK)
        else $error("released period driven high or flagged");

    // Read data appears only on the last period of a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data != 16'd0 |-> done_res && clock_pulse)
        else $error("read data outside the final period");

endmodule

bind mdio_clause45_master_core mdc45_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .clock_pulse  (rsp.clock_pulse),
    .data_level   (rsp.data_level),
    .drive_enable (rsp.drive_enable),
    .done_res     (rsp.done_res),
    .read_data    (rsp.read_data)
);
